### rtl/v2n_pkg.sv
// shared constants for the 2-d vector normalizer
// no dependencies; used by every rtl file of the block
package v2n_pkg;

  localparam int unsigned COORD_BITS_DEF     = 16;
  localparam int unsigned UNIT_FRAC_BITS_DEF = 14;
  localparam int unsigned UNIT_W             = 16;
  localparam int unsigned SQ_W               = 33;
  localparam int unsigned QUEUE_DEPTH        = 4;

  localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};

endpackage

### rtl/vector2d_normalize.sv
// 2-d vector normalizer: unit vector in signed q1.14 plus squared length
// uses v2n_pkg, v2n_front, v2n_queue and v2n_back
//
// input channel: an item (mode, this point, other point) is taken at a clock
// edge where push is high and full is low. mode 0 normalizes the point itself,
// mode 1 the vector from this point toward the other point.
// result channel: while empty is low the oldest result is on the result ports;
// it leaves at an edge where pop is high. a zero vector gives zero unit
// components with zero_length set.
// throughput: one item per cycle while full stays low. an accepted item reaches
// the result ports through the first front stage (difference), loaded at the
// accept edge, then the squares stage, the middle queue and UNIT_FRAC_BITS + 1
// back stages, each resolving one bit of both unit components.
// when pop stays low the back stages fill up, then the queue, then the front
// stages, and full rises; bubbles close up on the way. reset empties every
// stage and the queue; nothing else needs clearing.
module vector2d_normalize #(
  parameter int unsigned COORD_BITS     = v2n_pkg::COORD_BITS_DEF,
  parameter int unsigned UNIT_FRAC_BITS = v2n_pkg::UNIT_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              mode_i,
  input  logic signed [COORD_BITS-1:0]      this_x_i,
  input  logic signed [COORD_BITS-1:0]      this_y_i,
  input  logic signed [COORD_BITS-1:0]      other_x_i,
  input  logic signed [COORD_BITS-1:0]      other_y_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [v2n_pkg::UNIT_W-1:0] unit_x_o,
  output logic signed [v2n_pkg::UNIT_W-1:0] unit_y_o,
  output logic [v2n_pkg::SQ_W-1:0]          sq_length_o,
  output logic                              zero_length_o
);

  localparam int unsigned PW = 2 * COORD_BITS;
  localparam int unsigned SW = 2 * COORD_BITS + 1;
  localparam int unsigned QW = 2 * PW + SW + 2;

  logic          f_valid, f_ready, q_full, q_empty, b_ready;
  logic [PW-1:0] f_sx, f_sy, q_sx, q_sy;
  logic [SW-1:0] f_s, q_s;
  logic          f_nx, f_ny, q_nx, q_ny;
  logic [QW-1:0] q_din, q_dout;

  v2n_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .mode_i      (mode_i),
    .this_x_i    (this_x_i),
    .this_y_i    (this_y_i),
    .other_x_i   (other_x_i),
    .other_y_i   (other_y_i),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_sx_o    (f_sx),
    .out_sy_o    (f_sy),
    .out_s_o     (f_s),
    .out_negx_o  (f_nx),
    .out_negy_o  (f_ny)
  );

  assign f_ready = !q_full;
  assign q_din   = {f_sx, f_sy, f_s, f_nx, f_ny};
  assign {q_sx, q_sy, q_s, q_nx, q_ny} = q_dout;

  v2n_queue #(
    .WIDTH (QW),
    .DEPTH (v2n_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .full_o  (q_full),
    .data_i  (q_din),
    .pop_i   (b_ready),
    .empty_o (q_empty),
    .data_o  (q_dout)
  );

  v2n_back #(
    .COORD_BITS     (COORD_BITS),
    .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (!q_empty),
    .ready_o       (b_ready),
    .sx_i          (q_sx),
    .sy_i          (q_sy),
    .s_i           (q_s),
    .negx_i        (q_nx),
    .negy_i        (q_ny),
    .empty_o       (empty),
    .pop_i         (pop),
    .unit_x_o      (unit_x_o),
    .unit_y_o      (unit_y_o),
    .sq_length_o   (sq_length_o),
    .zero_length_o (zero_length_o)
  );

endmodule

### rtl/v2n_front.sv
// front pipeline: forms the difference vector, magnitudes, signs and squares
// uses v2n_pkg for its parameter default; feeds v2n_queue
module v2n_front #(
  parameter int unsigned COORD_BITS = v2n_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic                         mode_i,
  input  logic signed [COORD_BITS-1:0] this_x_i,
  input  logic signed [COORD_BITS-1:0] this_y_i,
  input  logic signed [COORD_BITS-1:0] other_x_i,
  input  logic signed [COORD_BITS-1:0] other_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2*COORD_BITS-1:0]      out_sx_o,
  output logic [2*COORD_BITS-1:0]      out_sy_o,
  output logic [2*COORD_BITS:0]        out_s_o,
  output logic                         out_negx_o,
  output logic                         out_negy_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned SW = 2 * COORD_BITS + 1;

  logic signed [DW-1:0]   dx, dy;
  logic [COORD_BITS-1:0]  mx, my;
  logic                   rdy1, rdy2, acc;
  logic                   v1_q, v2_q;
  logic [COORD_BITS-1:0]  mx_q, my_q;
  logic                   nx_q, ny_q, nx2_q, ny2_q;
  logic [2*COORD_BITS-1:0] sx_q, sy_q;

  always_comb begin
    if (mode_i) begin
      dx = DW'(other_x_i) - DW'(this_x_i);
      dy = DW'(other_y_i) - DW'(this_y_i);
    end else begin
      dx = DW'(this_x_i);
      dy = DW'(this_y_i);
    end
    // magnitude never reaches 2^COORD_BITS
    mx = dx[DW-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    my = dy[DW-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
  end

  assign rdy2   = !v2_q || out_ready_i;
  assign rdy1   = !v1_q || rdy2;
  assign full_o = !rdy1;
  assign acc    = push_i && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= acc;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mx_q <= mx;
      my_q <= my;
      nx_q <= dx[DW-1];
      ny_q <= dy[DW-1];
    end
    if (rdy2 && v1_q) begin
      sx_q  <= mx_q * mx_q;
      sy_q  <= my_q * my_q;
      nx2_q <= nx_q;
      ny2_q <= ny_q;
    end
  end

  assign out_valid_o = v2_q;
  assign out_sx_o    = sx_q;
  assign out_sy_o    = sy_q;
  assign out_s_o     = SW'(sx_q) + SW'(sy_q);
  assign out_negx_o  = nx2_q;
  assign out_negy_o  = ny2_q;

endmodule

### rtl/v2n_queue.sv
// short register queue between the front and back pipelines
// uses v2n_pkg for its depth default
module v2n_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = v2n_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
      if (do_pop)  rptr_q <= (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

endmodule

### rtl/v2n_back.sv
// back pipeline: one result bit per stage for both unit components, then output
// uses v2n_pkg; fed from v2n_queue
module v2n_back #(
  parameter int unsigned COORD_BITS     = v2n_pkg::COORD_BITS_DEF,
  parameter int unsigned UNIT_FRAC_BITS = v2n_pkg::UNIT_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [2*COORD_BITS-1:0]           sx_i,
  input  logic [2*COORD_BITS-1:0]           sy_i,
  input  logic [2*COORD_BITS:0]             s_i,
  input  logic                              negx_i,
  input  logic                              negy_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic signed [v2n_pkg::UNIT_W-1:0] unit_x_o,
  output logic signed [v2n_pkg::UNIT_W-1:0] unit_y_o,
  output logic [v2n_pkg::SQ_W-1:0]          sq_length_o,
  output logic                              zero_length_o
);

  localparam int unsigned F  = UNIT_FRAC_BITS;
  localparam int unsigned N  = F + 1;
  localparam int unsigned L  = N - 1;
  localparam int unsigned SW = 2 * COORD_BITS + 1;
  localparam int unsigned PW = 2 * COORD_BITS;
  localparam int unsigned W  = SW + 2 * F + 4;
  localparam int unsigned EW = (SW > v2n_pkg::SQ_W) ? SW : v2n_pkg::SQ_W;

  // a = q*q*s and b = q*s tracked by shifts and adds; the candidate with bit
  // set is kept when (2q-1)^2 * s <= sq * 2^(2F+2)
  function automatic logic [2*W:0] root_step(input logic [W-1:0] a, input logic [W-1:0] b,
                                             input logic [W-1:0] s, input logic [W-1:0] sq,
                                             input int unsigned bt);
    logic [W-1:0] an, bn, t, r;
    an = a + (b << (bt + 1)) + (s << (2 * bt));
    bn = b + (s << bt);
    t  = (an << 2) - (bn << 2) + s;
    r  = sq << (2 * F + 2);
    if (t <= r) return {1'b1, an, bn};
    return {1'b0, a, b};
  endfunction

  logic         v_q  [N];
  logic [W-1:0] ax_q [N];
  logic [W-1:0] bx_q [N];
  logic [W-1:0] ay_q [N];
  logic [W-1:0] by_q [N];
  logic [F:0]   qx_q [N];
  logic [F:0]   qy_q [N];
  logic [SW-1:0] s_q [N];
  logic [PW-1:0] sx_q [N];
  logic [PW-1:0] sy_q [N];
  logic         nx_q [N];
  logic         ny_q [N];
  logic [N:0]   rdy;

  assign rdy[N]  = pop_i;
  assign ready_o = rdy[0];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int unsigned BT = F - k;
    logic          pv, pnx, pny;
    logic [W-1:0]  pax, pbx, pay, pby;
    logic [F:0]    pqx, pqy;
    logic [SW-1:0] ps;
    logic [PW-1:0] psx, psy;
    logic [2*W:0]  resx, resy;

    if (k == 0) begin : g_head
      assign pv  = valid_i;
      assign pax = '0;
      assign pbx = '0;
      assign pay = '0;
      assign pby = '0;
      assign pqx = '0;
      assign pqy = '0;
      assign ps  = s_i;
      assign psx = sx_i;
      assign psy = sy_i;
      assign pnx = negx_i;
      assign pny = negy_i;
    end else begin : g_body
      assign pv  = v_q[k-1];
      assign pax = ax_q[k-1];
      assign pbx = bx_q[k-1];
      assign pay = ay_q[k-1];
      assign pby = by_q[k-1];
      assign pqx = qx_q[k-1];
      assign pqy = qy_q[k-1];
      assign ps  = s_q[k-1];
      assign psx = sx_q[k-1];
      assign psy = sy_q[k-1];
      assign pnx = nx_q[k-1];
      assign pny = ny_q[k-1];
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];
    assign resx   = root_step(pax, pbx, W'(ps), W'(psx), BT);
    assign resy   = root_step(pay, pby, W'(ps), W'(psy), BT);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && pv) begin
        ax_q[k] <= resx[2*W-1:W];
        bx_q[k] <= resx[W-1:0];
        ay_q[k] <= resy[2*W-1:W];
        by_q[k] <= resy[W-1:0];
        qx_q[k] <= pqx | ((F+1)'(resx[2*W]) << BT);
        qy_q[k] <= pqy | ((F+1)'(resy[2*W]) << BT);
        s_q[k]  <= ps;
        sx_q[k] <= psx;
        sy_q[k] <= psy;
        nx_q[k] <= pnx;
        ny_q[k] <= pny;
      end
    end
  end

  logic signed [F+1:0] qsx, qsy;
  logic [EW-1:0]       sext;

  always_comb begin
    qsx = signed'({1'b0, qx_q[L]});
    qsy = signed'({1'b0, qy_q[L]});
    if (nx_q[L]) qsx = -qsx;
    if (ny_q[L]) qsy = -qsy;
    sext = EW'(s_q[L]);
  end

  assign empty_o       = !v_q[L];
  assign zero_length_o = (s_q[L] == '0);
  assign unit_x_o      = zero_length_o ? '0 : v2n_pkg::UNIT_W'(qsx);
  assign unit_y_o      = zero_length_o ? '0 : v2n_pkg::UNIT_W'(qsy);
  assign sq_length_o   = (sext > EW'(v2n_pkg::SQ_MAX)) ? v2n_pkg::SQ_MAX
                                                         : v2n_pkg::SQ_W'(sext);

  // a nonzero vector never yields a component above one
  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[L] && (s_q[L] != '0) |-> (qx_q[L] <= {1'b1, {F{1'b0}}}) &&
                                 (qy_q[L] <= {1'b1, {F{1'b0}}}))
    else $error("unit component above one");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[L] && !pop_i |=> v_q[L])
    else $error("waiting result lost");

  a_take_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && rdy[0] |=> v_q[0])
    else $error("item taken from queue but not in first stage");

endmodule
